FILE: rtl/prlc_pkg.sv
// Shared types and constants for the rate-limited PID controller.
// Used by prlc_mul, prlc_div and pid_rate_limited_controller_core.
package prlc_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 33;
  localparam int PROD_W        = 2 * OP_W;
  localparam int DT_W          = 24;
  localparam int SLEW_W        = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_W         = 56;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  localparam logic [DT_W-1:0] US_PER_S = DT_W'(1000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_LIMIT_HIGH,
    REG_LIMIT_LOW,
    REG_SLEW_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_M,
    ST_DIV_I,
    ST_WAIT_I,
    ST_INTEG,
    ST_DIV_D,
    ST_WAIT_D,
    ST_SUM,
    ST_DIV_S,
    ST_WAIT_S,
    ST_SLEW,
    ST_FIN
  } pid_state_t;

  typedef struct packed {
    logic            start;
    logic [DT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/prlc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on prlc_pkg.
module prlc_mul
  import prlc_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

FILE: rtl/prlc_div.sv
// Iterative signed-by-unsigned divider, quotient rounded toward minus infinity.
// Restoring, DIV_STEP_BITS quotient bits per cycle. Depends on prlc_pkg.
module prlc_div
  import prlc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  div_req_t                req,
  input  logic signed [DIV_W-1:0] dividend,
  output div_rsp_t                rsp
);

  div_state_t           state;
  div_state_t           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     work;
  logic [DIV_W-1:0]     work_next;
  logic [DT_W-1:0]      rem;
  logic [DT_W-1:0]      rem_next;
  logic [DT_W-1:0]      divisor;
  logic                 neg;
  logic [DIV_W-1:0]     quot;
  logic                 done;

  always_comb begin
    logic [DT_W:0] trial;
    rem_next  = rem;
    work_next = work;
    trial     = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial     = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial        = trial - {1'b0, divisor};
        work_next[0] = 1'b1;
      end
      rem_next = trial[DT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (req.start) state_next = DIV_RUN;
      end
      DIV_RUN: begin
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) state_next = DIV_FIX;
      end
      DIV_FIX: state_next = DIV_IDLE;
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DIV_FIX);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (req.start) begin
          neg     <= dividend[DIV_W-1];
          work    <= dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;
          rem     <= '0;
          cnt     <= '0;
          divisor <= req.divisor;
        end
      end
      DIV_RUN: begin
        work <= work_next;
        rem  <= rem_next;
        cnt  <= cnt + 1'b1;
      end
      DIV_FIX: begin
        // floor for negative dividends: bump the magnitude on a nonzero remainder
        quot <= neg ? ~(work + DIV_W'(rem != '0)) + 1'b1 : work;
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

FILE: rtl/pid_rate_limited_controller_core.sv
// PID controller with trapezoidal integral, derivative over the time step
// and optional slew-rate limit, Q16.16. Depends on prlc_pkg, prlc_mul, prlc_div.
//
//  channel   dir  fields (tdata from bit 0)          transfer when
//  s_*       in   error_in[31:0], now_us[63:32]      s_tvalid & s_tready
//  m_*       out  drive[31:0]                        m_tvalid & m_tready
//  cfg_*     in   cfg_addr index, cfg_data value     cfg_wen
//
// Each item makes two passes through the shared divider with slew limit off and
// three with it on, and uses the shared multiplier in ST_MUL_P, ST_MUL_I,
// ST_MUL_D, ST_MUL_M, ST_INTEG and ST_SUM, all under the sequencer.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register; the final step holds while it is full and m_tready is low.
// Reset is synchronous: config registers to their defaults, loop state to zero.
module pid_rate_limited_controller_core
  import prlc_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int DEFAULT_STEP_US = 1000,
  parameter int MAX_STEP_US     = 500000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // error_in[31:0], now_us[63:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // drive[31:0]
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam logic [DATA_W-1:0] MAX_STEP     = DATA_W'(MAX_STEP_US);
  localparam logic [DT_W-1:0]   DEFAULT_STEP = DT_W'(DEFAULT_STEP_US);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if ((&x[PROD_W-1:DATA_W-1]) || ~(|x[PROD_W-1:DATA_W-1])) r = x[DATA_W-1:0];
    else if (x[PROD_W-1]) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_lim(
    input logic signed [PROD_W-1:0] x,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [DATA_W-1:0] r;
    if (x < PROD_W'(lo)) r = lo;
    else if (x > PROD_W'(hi)) r = hi;
    else r = x[DATA_W-1:0];
    return r;
  endfunction

  logic signed [DATA_W-1:0] gain_prop;
  logic signed [DATA_W-1:0] gain_integ;
  logic signed [DATA_W-1:0] gain_deriv;
  logic signed [DATA_W-1:0] limit_high;
  logic signed [DATA_W-1:0] limit_low;
  logic [SLEW_W-1:0]        slew_limit;

  logic signed [DATA_W-1:0] last_error;
  logic signed [DATA_W-1:0] integ_acc;
  logic signed [DATA_W-1:0] last_drive;
  logic [DATA_W-1:0]        last_time;

  logic signed [DATA_W-1:0] err;
  logic [DATA_W-1:0]        now;
  logic [DT_W-1:0]          dt;
  logic signed [DATA_W-1:0] p_term;
  logic signed [DATA_W-1:0] m_term;
  logic signed [DATA_W-1:0] q_term;
  logic signed [DATA_W-1:0] integral;
  logic signed [DATA_W-1:0] y;
  logic signed [DATA_W-1:0] y_slew;

  logic                     out_valid;
  logic [DATA_W-1:0]        out_drive;

  pid_state_t               state;
  pid_state_t               state_next;
  logic                     fin_go;

  logic [DATA_W-1:0]        dt_raw;
  logic [DT_W-1:0]          dt_sel;

  logic                     mul_en;
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [PROD_W-1:0] quot_w;

  prlc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  prlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (prod[DIV_W-1:0]),
    .rsp      (div_rsp)
  );

  assign quot_w = PROD_W'($signed(div_rsp.quot));

  assign dt_raw = s_tdata[63:32] - last_time;
  assign dt_sel = (dt_raw == '0 || dt_raw > MAX_STEP) ? DEFAULT_STEP : dt_raw[DT_W-1:0];

  assign fin_go = (state == ST_FIN) && (!out_valid || m_tready);

  always_comb begin
    logic signed [PROD_W-1:0] diff;
    diff   = PROD_W'(y) - PROD_W'(last_drive);
    y_slew = y;
    if (diff > quot_w) begin
      y_slew = DATA_W'(PROD_W'(last_drive) + quot_w);
    end else if (diff < -quot_w) begin
      y_slew = DATA_W'(PROD_W'(last_drive) - quot_w);
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_I;
      ST_MUL_I:  state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_MUL_M;
      ST_MUL_M:  state_next = ST_DIV_I;
      ST_DIV_I:  state_next = ST_WAIT_I;
      ST_WAIT_I: if (div_rsp.done) state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_DIV_D;
      ST_DIV_D:  state_next = ST_WAIT_D;
      ST_WAIT_D: if (div_rsp.done) state_next = ST_SUM;
      ST_SUM:    state_next = (slew_limit != '0) ? ST_DIV_S : ST_FIN;
      ST_DIV_S:  state_next = ST_WAIT_S;
      ST_WAIT_S: if (div_rsp.done) state_next = ST_SLEW;
      ST_SLEW:   state_next = ST_FIN;
      ST_FIN:    if (fin_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer: unit control
  always_comb begin
    s_tready        = (state == ST_IDLE);
    mul_en          = 1'b1;
    mul_a           = '0;
    mul_b           = '0;
    div_req.start   = 1'b0;
    div_req.divisor = US_PER_S;
    case (state)
      ST_MUL_P: begin
        mul_a = OP_W'(gain_prop);
        mul_b = OP_W'(err);
      end
      ST_MUL_I: begin
        mul_a = OP_W'(gain_integ);
        mul_b = OP_W'(err) + OP_W'(last_error);
      end
      ST_MUL_D: begin
        mul_a = OP_W'(gain_deriv);
        mul_b = OP_W'(err) - OP_W'(last_error);
      end
      ST_MUL_M: begin
        mul_a = OP_W'(m_term);
        mul_b = OP_W'(dt);
      end
      ST_INTEG: begin
        mul_a = OP_W'(q_term);
        mul_b = OP_W'(US_PER_S);
      end
      ST_SUM: begin
        mul_a = OP_W'(slew_limit);
        mul_b = OP_W'(dt);
      end
      ST_DIV_I, ST_DIV_S: begin
        mul_en        = 1'b0;
        div_req.start = 1'b1;
      end
      ST_DIV_D: begin
        mul_en          = 1'b0;
        div_req.start   = 1'b1;
        div_req.divisor = dt;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      gain_prop  <= DATA_W'(65536);
      gain_integ <= '0;
      gain_deriv <= '0;
      limit_high <= {1'b0, {(DATA_W-1){1'b1}}};
      limit_low  <= {1'b1, {(DATA_W-1){1'b0}}};
      slew_limit <= '0;
      last_error <= '0;
      integ_acc  <= '0;
      last_drive <= '0;
      last_time  <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GAIN_PROP:  gain_prop  <= cfg_data;
          REG_GAIN_INTEG: gain_integ <= cfg_data;
          REG_GAIN_DERIV: gain_deriv <= cfg_data;
          REG_LIMIT_HIGH: limit_high <= cfg_data;
          REG_LIMIT_LOW:  limit_low  <= cfg_data;
          REG_SLEW_LIMIT: slew_limit <= cfg_data[SLEW_W-1:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid  <= 1'b1;
        last_error <= err;
        integ_acc  <= integral;
        last_drive <= y;
        last_time  <= now;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          err <= s_tdata[31:0];
          now <= s_tdata[63:32];
          dt  <= dt_sel;
        end
      end
      ST_MUL_I:  p_term <= sat32(prod >>> FRAC_BITS);
      ST_MUL_D:  m_term <= sat32(prod >>> (FRAC_BITS + 1));
      ST_MUL_M:  q_term <= sat32(prod >>> FRAC_BITS);
      ST_INTEG:  integral <= clamp_lim(PROD_W'(integ_acc) + quot_w, limit_low, limit_high);
      ST_SUM:    y <= clamp_lim(PROD_W'(p_term) + PROD_W'(integral) + quot_w,
                                limit_low, limit_high);
      ST_SLEW:   y <= y_slew;
      ST_FIN:    if (fin_go) out_drive <= y;
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_drive;

endmodule

FILE: verif/pid_loop_checker.sv
// Checker for pid_rate_limited_controller_core: watches the config port and both
// stream channels, predicts each drive value and compares it in order.
// Depends on prlc_pkg for the register index enum and port widths.
module pid_loop_checker
  import prlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [63:0]          s_tdata,   // error_in[31:0], now_us[63:32]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,   // drive[31:0]
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   errors,
  output int                   accepted,
  output int                   outstanding
);

  localparam int FRAC_BITS       = 16;
  localparam int DEFAULT_STEP_US = 1000;
  localparam int MAX_STEP_US     = 500000;

  typedef logic signed [79:0] wide_t;

  localparam wide_t MICROS  = 1000000;
  localparam wide_t POS_MAX = 2147483647;
  localparam wide_t NEG_MIN = -POS_MAX - 1;

  logic signed [31:0] kp, ki, kd, lim_hi, lim_lo;
  logic [SLEW_W-1:0]  slew;
  logic signed [31:0] prev_err, integ, prev_drive;
  logic [31:0]        prev_stamp;

  logic [31:0] drive_q[$];

  initial begin
    errors      = 0;
    accepted    = 0;
    outstanding = 0;
  end

  function automatic wide_t fdiv(input wide_t x, input wide_t d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic wide_t sat(input wide_t x);
    if (x > POS_MAX) return POS_MAX;
    if (x < NEG_MIN) return NEG_MIN;
    return x;
  endfunction

  // low limit tested first: crossed limits give lim_lo below it, else lim_hi
  function automatic wide_t clamp_lim(input wide_t x);
    if (x < lim_lo) return lim_lo;
    if (x > lim_hi) return lim_hi;
    return x;
  endfunction

  task automatic advance_loop(input logic signed [31:0] e, input logic [31:0] stamp,
                              output logic [31:0] drive);
    logic [31:0] span;
    wide_t dt, p, m, integ_n, q, d, y, step, diff;
    span = stamp - prev_stamp;
    if (span == 0 || span > MAX_STEP_US) dt = DEFAULT_STEP_US;
    else dt = $signed({48'd0, span});
    p = sat((wide_t'(kp) * e) >>> FRAC_BITS);
    m = sat((wide_t'(ki) * e + wide_t'(ki) * prev_err) >>> (FRAC_BITS + 1));
    integ_n = clamp_lim(wide_t'(integ) + fdiv(m * dt, MICROS));
    q = sat((wide_t'(kd) * (wide_t'(e) - prev_err)) >>> FRAC_BITS);
    d = fdiv(q * MICROS, dt);
    y = clamp_lim(p + integ_n + d);
    if (slew != 0) begin
      step = fdiv($signed({49'd0, slew}) * dt, MICROS);
      diff = y - wide_t'(prev_drive);
      if (diff > step) y = wide_t'(prev_drive) + step;
      else if (diff < -step) y = wide_t'(prev_drive) - step;
    end
    prev_err   = e;
    integ      = integ_n[31:0];
    prev_drive = y[31:0];
    prev_stamp = stamp;
    drive      = y[31:0];
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      kp         = 32'sd65536;
      ki         = '0;
      kd         = '0;
      lim_hi     = 32'h7FFF_FFFF;
      lim_lo     = 32'h8000_0000;
      slew       = '0;
      prev_err   = '0;
      integ      = '0;
      prev_drive = '0;
      prev_stamp = '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GAIN_PROP:  kp = cfg_data;
          REG_GAIN_INTEG: ki = cfg_data;
          REG_GAIN_DERIV: kd = cfg_data;
          REG_LIMIT_HIGH: lim_hi = cfg_data;
          REG_LIMIT_LOW:  lim_lo = cfg_data;
          REG_SLEW_LIMIT: slew = cfg_data[SLEW_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: drive %h with no transfer pending, expected none", $time, m_tdata);
          errors++;
        end else begin
          want = drive_q.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: drive expected %h actual %h", $time, want, m_tdata);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_loop(s_tdata[31:0], s_tdata[63:32], want);
        drive_q.push_back(want);
        accepted++;
      end
    end
    outstanding = drive_q.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the testbench for pid_rate_limited_controller_core: clock, reset,
// config writes, sample stimulus with idling phases, verdict.
// Depends on prlc_pkg, the core and pid_loop_checker.
module testbench
  import prlc_pkg::*;
();

  localparam int MAX_STEP_US = 500000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 144;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [63:0]          s_tdata;   // error_in[31:0], now_us[63:32]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;   // drive[31:0]
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [DATA_W-1:0]    cfg_data;

  int errors, accepted, outstanding;
  int send_pct, recv_pct;
  int cycles;
  logic [31:0] stamp_us;

  pid_rate_limited_controller_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  pid_loop_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .accepted    (accepted),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_pct);
  end

  task automatic send_sample(input logic [31:0] err, input logic [31:0] stamp);
    int target;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_pct);
    end
    target   = accepted + 1;
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, err};
    stamp_us = stamp;
    do @(negedge clk); while (accepted != target);
  endtask

  // quiesce: no transfer pending, sequencer back in idle
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wen  <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic program_loop(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] hi,
                              input logic [31:0] lo, input logic [31:0] slew);
    cfg_write(REG_GAIN_PROP, kp);
    cfg_write(REG_GAIN_INTEG, ki);
    cfg_write(REG_GAIN_DERIV, kd);
    cfg_write(REG_LIMIT_HIGH, hi);
    cfg_write(REG_LIMIT_LOW, lo);
    cfg_write(REG_SLEW_LIMIT, slew);
    // unmapped index, must be ignored
    cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [31:0] rand_error();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return int'($urandom_range(1048576)) - 524288;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return int'($urandom_range(524288)) - 262144;
    endcase
  endfunction

  function automatic logic [31:0] next_stamp(input logic [31:0] prev);
    case ($urandom_range(19))
      0: return prev;
      1: return prev - $urandom_range(1, 100000);
      2: return prev + MAX_STEP_US + $urandom_range(1);
      3: return $urandom;
      4, 5: return prev + $urandom_range(20000, 700000);
      default: return prev + $urandom_range(1, 20000);
    endcase
  endfunction

  initial begin
    logic [31:0] hi, lo, tmp, slew;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    cfg_wen  = 1'b0;
    cfg_addr = REG_GAIN_PROP;
    cfg_data = '0;
    send_pct = 0;
    recv_pct = 0;
    stamp_us = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: field extremes and time step corners
    send_sample(32'h7FFF_FFFF, 32'd0);           // zero step
    send_sample(32'h8000_0000, 32'd0);
    send_sample(32'h0, 32'd500000);              // step at the maximum
    send_sample(32'hFFFF_FFFF, 32'd1000001);     // just above it
    send_sample(32'h0001_0000, 32'd1000000);     // timestamp going back
    send_sample(32'hFFFF_0000, 32'hFFFF_FF00);
    send_sample(32'd12345, 32'h0000_0010);       // forward across the wrap
    settle();

    // extreme gains, crossed limits
    program_loop(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_0000, 32'h0001_0000, 32'h0);
    send_sample(32'h7FFF_FFFF, 32'h0000_0400);
    send_sample(32'h8000_0000, 32'h0000_0401);
    send_sample(32'h0000_0001, 32'h0007_A120);
    settle();

    program_loop(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h0007_A121);
    send_sample(32'h7FFF_FFFF, 32'h0007_A122);
    send_sample(32'hFFFF_FFFF, 32'h0007_A122);
    settle();

    // narrow limits with tight slew; drive may start outside the limits
    program_loop(32'd65536, 32'd655360, 32'd655, 32'h0064_0000,
                 32'hFF9C_0000, 32'd3276800);
    send_sample(32'h0010_0000, 32'h0007_E000);
    send_sample(32'hFFF0_0000, 32'h0008_2000);
    send_sample(32'h0000_8000, 32'h0008_2001);
    send_sample(32'h7FFF_FFFF, 32'h000C_0000);
    send_sample(32'h8000_0000, 32'h0001_0000);
    send_sample(32'h0, 32'h0001_03E8);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 81; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 81; end
        default: begin send_pct = 31; recv_pct = 31; end
      endcase
      case ($urandom_range(9))
        0: begin
          hi = 32'h7FFF_FFFF;
          lo = 32'h8000_0000;
        end
        1: begin
          hi = $urandom;
          lo = $urandom;
        end
        default: begin
          hi = int'($urandom_range(16777216)) - 8388608;
          lo = int'($urandom_range(16777216)) - 8388608;
          if ($signed(lo) > $signed(hi)) begin
            tmp = hi;
            hi  = lo;
            lo  = tmp;
          end
        end
      endcase
      case ($urandom_range(4))
        0, 1: slew = 32'h0;
        2, 3: slew = $urandom_range(1, 131072000);
        default: slew = $urandom;
      endcase
      program_loop(rand_gain(), rand_gain(), rand_gain(), hi, lo, slew);
      repeat (PER_PHASE) send_sample(rand_error(), next_stamp(stamp_us));
    end

    settle();
    repeat (80) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
